// ===== rtl/pmhc_pkg.sv =====
package pmhc_pkg;

  localparam int unsigned LEVEL_W    = 12;
  localparam int unsigned TEMP_W     = 11;
  localparam int unsigned HUM_W      = 10;
  localparam int unsigned RUN_W      = 16;
  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned EVENT_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Moisture at or above this reads as an open sensor
  localparam logic [LEVEL_W-1:0] OPEN_LEVEL   = 12'd4090;
  // Minimum pump run before a sample may stop it
  localparam logic [LEVEL_W-1:0] MIN_ON_TICKS = 12'd3000;

  localparam logic [LEVEL_W-1:0]        ON_LEVEL_RST   = 12'd500;
  localparam logic [LEVEL_W-1:0]        OFF_LEVEL_RST  = 12'd1500;
  localparam logic [LEVEL_W-1:0]        RES_LEVEL_RST  = 12'd500;
  localparam logic signed [TEMP_W-1:0]  TEMP_LEVEL_RST = 11'sd300;
  localparam logic [HUM_W-1:0]          HUM_LEVEL_RST  = 10'd250;
  localparam logic [RUN_W-1:0]          PUMP_RUN_RST   = 16'd5000;
  localparam logic [RUN_W-1:0]          PUMP_COOL_RST  = 16'd60000;
  localparam logic [RUN_W-1:0]          MIST_RUN_RST   = 16'd3000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK     = 3'd0,
    ACT_SAMPLE   = 3'd1,
    ACT_PUMP_ON  = 3'd2,
    ACT_PUMP_OFF = 3'd3,
    ACT_MIST_ON  = 3'd4,
    ACT_MIST_OFF = 3'd5,
    ACT_SET_MODE = 3'd6
  } action_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_STOP  = 2'd2
  } pump_event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ON_LEVEL   = 3'd0,
    REG_OFF_LEVEL  = 3'd1,
    REG_RES_LEVEL  = 3'd2,
    REG_TEMP_LEVEL = 3'd3,
    REG_HUM_LEVEL  = 3'd4,
    REG_PUMP_RUN   = 3'd5,
    REG_PUMP_COOL  = 3'd6,
    REG_MIST_RUN   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [LEVEL_W-1:0]       on_level;
    logic [LEVEL_W-1:0]       off_level;
    logic [LEVEL_W-1:0]       res_level;
    logic signed [TEMP_W-1:0] temp_level;
    logic [HUM_W-1:0]         hum_level;
    logic [RUN_W-1:0]         pump_run;
    logic [RUN_W-1:0]         pump_cool;
    logic [RUN_W-1:0]         mist_run;
  } cfg_t;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic [LEVEL_W-1:0]       moisture;
    logic [LEVEL_W-1:0]       reservoir_level;
    logic signed [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]         humidity;
    logic                     mode_value;
  } item_t;

  typedef struct packed {
    logic               pump_active;
    logic               mist_active;
    logic               reservoir_is_low;
    logic               dry_alert;
    logic               sensor_open;
    logic [EVENT_W-1:0] pump_event;
    logic               auto_active;
  } result_t;

endpackage

// ===== rtl/pmhc_if.sv =====
interface pmhc_in_if;
  import pmhc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ACTION_W-1:0]      action;
  logic [LEVEL_W-1:0]       moisture;
  logic [LEVEL_W-1:0]       reservoir_level;
  logic signed [TEMP_W-1:0] temperature;
  logic [HUM_W-1:0]         humidity;
  logic                     mode_value;

  modport source (
    output valid, action, moisture, reservoir_level, temperature, humidity, mode_value,
    input  ready
  );
  modport sink (
    input  valid, action, moisture, reservoir_level, temperature, humidity, mode_value,
    output ready
  );
endinterface

interface pmhc_out_if;
  import pmhc_pkg::*;
  logic               valid;
  logic               ready;
  logic               pump_active;
  logic               mist_active;
  logic               reservoir_is_low;
  logic               dry_alert;
  logic               sensor_open;
  logic [EVENT_W-1:0] pump_event;
  logic               auto_active;

  modport source (
    output valid, pump_active, mist_active, reservoir_is_low, dry_alert, sensor_open,
           pump_event, auto_active,
    input  ready
  );
  modport sink (
    input  valid, pump_active, mist_active, reservoir_is_low, dry_alert, sensor_open,
           pump_event, auto_active,
    output ready
  );
endinterface

interface pmhc_cfg_if;
  import pmhc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/pmhc_cfg_regs.sv =====
module pmhc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [pmhc_pkg::CFG_IDX_W-1:0]  idx_i,
  input  logic [pmhc_pkg::CFG_DATA_W-1:0] data_i,
  output pmhc_pkg::cfg_t                  cfg_o
);
  import pmhc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_reg_e'(idx_i))
        REG_ON_LEVEL:   cfg_d.on_level   = data_i[LEVEL_W-1:0];
        REG_OFF_LEVEL:  cfg_d.off_level  = data_i[LEVEL_W-1:0];
        REG_RES_LEVEL:  cfg_d.res_level  = data_i[LEVEL_W-1:0];
        REG_TEMP_LEVEL: cfg_d.temp_level = $signed(data_i[TEMP_W-1:0]);
        REG_HUM_LEVEL:  cfg_d.hum_level  = data_i[HUM_W-1:0];
        REG_PUMP_RUN:   cfg_d.pump_run   = data_i[RUN_W-1:0];
        REG_PUMP_COOL:  cfg_d.pump_cool  = data_i[RUN_W-1:0];
        REG_MIST_RUN:   cfg_d.mist_run   = data_i[RUN_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_level   <= ON_LEVEL_RST;
      cfg_q.off_level  <= OFF_LEVEL_RST;
      cfg_q.res_level  <= RES_LEVEL_RST;
      cfg_q.temp_level <= TEMP_LEVEL_RST;
      cfg_q.hum_level  <= HUM_LEVEL_RST;
      cfg_q.pump_run   <= PUMP_RUN_RST;
      cfg_q.pump_cool  <= PUMP_COOL_RST;
      cfg_q.mist_run   <= MIST_RUN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/pmhc_core.sv =====
module pmhc_core #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  pmhc_pkg::item_t   item_i,
  input  pmhc_pkg::cfg_t    cfg_i,
  output pmhc_pkg::result_t result_o
);
  import pmhc_pkg::*;

  localparam int unsigned CMP_W = (TIME_WIDTH > RUN_W) ? TIME_WIDTH : RUN_W;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  logic                  pump_running_q, pump_running_d;
  logic                  mist_running_q, mist_running_d;
  logic                  res_low_q, res_low_d;
  logic                  alert_given_q, alert_given_d;
  logic                  auto_q, auto_d;
  logic [TIME_WIDTH-1:0] pump_elapsed_q, pump_elapsed_d;
  logic [TIME_WIDTH-1:0] since_stop_q, since_stop_d;
  logic [TIME_WIDTH-1:0] mist_elapsed_q, mist_elapsed_d;

  logic [TIME_WIDTH-1:0] pump_inc, since_inc, mist_inc;
  logic                  res_low_now;
  logic                  dry_alert, sensor_open;
  pump_event_e           pump_event;

  // Saturating counter steps
  assign pump_inc  = (pump_elapsed_q == TIME_MAX) ? TIME_MAX : pump_elapsed_q + 1'b1;
  assign since_inc = (since_stop_q == TIME_MAX) ? TIME_MAX : since_stop_q + 1'b1;
  assign mist_inc  = (mist_elapsed_q == TIME_MAX) ? TIME_MAX : mist_elapsed_q + 1'b1;

  assign res_low_now = item_i.reservoir_level < cfg_i.res_level;

  always_comb begin
    pump_running_d = pump_running_q;
    mist_running_d = mist_running_q;
    res_low_d      = res_low_q;
    alert_given_d  = alert_given_q;
    auto_d         = auto_q;
    pump_elapsed_d = pump_elapsed_q;
    since_stop_d   = since_stop_q;
    mist_elapsed_d = mist_elapsed_q;
    dry_alert      = 1'b0;
    sensor_open    = 1'b0;
    pump_event     = EV_NONE;

    unique case (action_e'(item_i.action))
      ACT_TICK: begin
        pump_elapsed_d = pump_inc;
        since_stop_d   = since_inc;
        mist_elapsed_d = mist_inc;
        if (pump_running_q && (CMP_W'(pump_inc) >= CMP_W'(cfg_i.pump_run))) begin
          pump_running_d = 1'b0;
          since_stop_d   = '0;
          pump_event     = EV_STOP;
        end
        if (mist_running_q && (CMP_W'(mist_inc) >= CMP_W'(cfg_i.mist_run))) begin
          mist_running_d = 1'b0;
        end
      end
      ACT_SAMPLE: begin
        res_low_d = res_low_now;
        if (auto_q) begin
          if (pump_running_q) begin
            if ((pump_elapsed_q >= TIME_WIDTH'(MIN_ON_TICKS)) &&
                (item_i.moisture > cfg_i.off_level)) begin
              pump_running_d = 1'b0;
              since_stop_d   = '0;
              pump_event     = EV_STOP;
            end
          end else begin
            // hold off during cooldown, open sensor and low reservoir
            priority if (CMP_W'(since_stop_q) < CMP_W'(cfg_i.pump_cool)) begin
              pump_event = EV_NONE;
            end else if (item_i.moisture >= OPEN_LEVEL) begin
              sensor_open = 1'b1;
            end else if (res_low_now) begin
              pump_event = EV_NONE;
            end else if (item_i.moisture < cfg_i.on_level) begin
              pump_running_d = 1'b1;
              pump_elapsed_d = '0;
              pump_event     = EV_START;
              if (!alert_given_q) begin
                dry_alert     = 1'b1;
                alert_given_d = 1'b1;
              end
            end else begin
              alert_given_d = 1'b0;
            end
          end
          if (!mist_running_q &&
              ($signed(item_i.temperature) > $signed(cfg_i.temp_level)) &&
              (item_i.humidity < cfg_i.hum_level)) begin
            mist_running_d = 1'b1;
            mist_elapsed_d = '0;
          end
        end
      end
      ACT_PUMP_ON: begin
        if (!pump_running_q && !res_low_q) begin
          pump_running_d = 1'b1;
          pump_elapsed_d = '0;
          pump_event     = EV_START;
        end
      end
      ACT_PUMP_OFF: begin
        pump_running_d = 1'b0;
        since_stop_d   = '0;
        pump_event     = EV_STOP;
      end
      ACT_MIST_ON: begin
        if (!mist_running_q) begin
          mist_running_d = 1'b1;
          mist_elapsed_d = '0;
        end
      end
      ACT_MIST_OFF: begin
        mist_running_d = 1'b0;
      end
      ACT_SET_MODE: begin
        auto_d = item_i.mode_value;
      end
      default: begin
        pump_event = EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pump_running_q <= 1'b0;
      mist_running_q <= 1'b0;
      res_low_q      <= 1'b0;
      alert_given_q  <= 1'b0;
      auto_q         <= 1'b1;
      pump_elapsed_q <= '0;
      since_stop_q   <= TIME_MAX;
      mist_elapsed_q <= '0;
    end else if (adv_i) begin
      pump_running_q <= pump_running_d;
      mist_running_q <= mist_running_d;
      res_low_q      <= res_low_d;
      alert_given_q  <= alert_given_d;
      auto_q         <= auto_d;
      pump_elapsed_q <= pump_elapsed_d;
      since_stop_q   <= since_stop_d;
      mist_elapsed_q <= mist_elapsed_d;
    end
  end

  assign result_o.pump_active      = pump_running_d;
  assign result_o.mist_active      = mist_running_d;
  assign result_o.reservoir_is_low = res_low_d;
  assign result_o.dry_alert        = dry_alert;
  assign result_o.sensor_open      = sensor_open;
  assign result_o.pump_event       = pump_event;
  assign result_o.auto_active      = auto_d;

endmodule

// ===== rtl/pump_mist_hysteresis_controller.sv =====
// Pipeline: an accepted item sits in the input register, and its result is registered
// when the item advances, which waits until the output register is empty or taken.
// Throughput: one item per cycle unless stalled; update is one compare-and-count pass.
// Reset: pump and mister off, counters cleared, cooldown counter at all ones,
// auto mode on, level and time registers back to their default values.
module pump_mist_hysteresis_controller #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pmhc_in_if.sink    in_i,
  pmhc_out_if.source out_o,
  pmhc_cfg_if.sink   cfg_i
);
  import pmhc_pkg::*;

  logic    in_valid_q, in_valid_d;
  item_t   item_q;
  logic    out_valid_q, out_valid_d;
  result_t result_q, result_d;
  cfg_t    cfg;
  logic    in_accept, adv;

  assign adv         = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || adv;
  assign in_accept   = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign in_valid_d  = in_accept ? 1'b1 : (adv ? 1'b0 : in_valid_q);
  assign out_valid_d = adv ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.action          <= in_i.action;
      item_q.moisture        <= in_i.moisture;
      item_q.reservoir_level <= in_i.reservoir_level;
      item_q.temperature     <= in_i.temperature;
      item_q.humidity        <= in_i.humidity;
      item_q.mode_value      <= in_i.mode_value;
    end
    if (adv) begin
      result_q <= result_d;
    end
  end

  pmhc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_i.valid && cfg_i.ready),
    .idx_i  (cfg_i.index),
    .data_i (cfg_i.data),
    .cfg_o  (cfg)
  );

  pmhc_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result_d)
  );

  assign out_o.valid            = out_valid_q;
  assign out_o.pump_active      = result_q.pump_active;
  assign out_o.mist_active      = result_q.mist_active;
  assign out_o.reservoir_is_low = result_q.reservoir_is_low;
  assign out_o.dry_alert        = result_q.dry_alert;
  assign out_o.sensor_open      = result_q.sensor_open;
  assign out_o.pump_event       = result_q.pump_event;
  assign out_o.auto_active      = result_q.auto_active;

  a_stop_clears_pump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (result_q.pump_event == EV_STOP) |-> !result_q.pump_active)
    else $error("pump reported stopped but still active");

  a_alert_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.dry_alert |-> (result_q.pump_event == EV_START) &&
    result_q.pump_active && result_q.auto_active)
    else $error("dry alert without an auto pump start");

  a_open_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.sensor_open |-> (result_q.pump_event == EV_NONE) &&
    !result_q.pump_active && result_q.auto_active)
    else $error("open sensor flagged alongside a pump change");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("item advanced but result register not valid");

endmodule

// ===== test/pump_mist_hysteresis_controller_tb.sv =====
module pump_mist_hysteresis_controller_tb;
  import pmhc_pkg::*;

  localparam int unsigned TIME_W = 16;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 90;

  class controller_scoreboard;
    logic [LEVEL_W-1:0]       on_lvl, off_lvl, res_lvl;
    logic signed [TEMP_W-1:0] temp_lvl;
    logic [HUM_W-1:0]         hum_lvl;
    logic [RUN_W-1:0]         pump_run, pump_cool, mist_run;
    bit                       pump_on, mist_on, res_low, alert_done, auto_on;
    logic [TIME_W-1:0]        pump_ms, cool_ms, mist_ms;
    result_t                  pending_outputs[$];
    int errors, items, results, starts, stops, alerts, opens;

    function new();
      on_lvl    = ON_LEVEL_RST;
      off_lvl   = OFF_LEVEL_RST;
      res_lvl   = RES_LEVEL_RST;
      temp_lvl  = TEMP_LEVEL_RST;
      hum_lvl   = HUM_LEVEL_RST;
      pump_run  = PUMP_RUN_RST;
      pump_cool = PUMP_COOL_RST;
      mist_run  = MIST_RUN_RST;
      pump_ms   = '0;
      mist_ms   = '0;
      cool_ms   = '1;
      auto_on   = 1'b1;
    endfunction

    function logic [TIME_W-1:0] sat_up(logic [TIME_W-1:0] c);
      return (&c) ? c : c + 1'b1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_ON_LEVEL:   on_lvl = d[LEVEL_W-1:0];
        REG_OFF_LEVEL:  off_lvl = d[LEVEL_W-1:0];
        REG_RES_LEVEL:  res_lvl = d[LEVEL_W-1:0];
        REG_TEMP_LEVEL: temp_lvl = d[TEMP_W-1:0];
        REG_HUM_LEVEL:  hum_lvl = d[HUM_W-1:0];
        REG_PUMP_RUN:   pump_run = d[RUN_W-1:0];
        REG_PUMP_COOL:  pump_cool = d[RUN_W-1:0];
        REG_MIST_RUN:   mist_run = d[RUN_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_item(item_t it);
      result_t     r;
      pump_event_e ev;
      bit          alert, open_s;
      r = '0;
      ev = EV_NONE;
      alert = 1'b0;
      open_s = 1'b0;
      items++;
      case (it.action)
        ACT_TICK: begin
          pump_ms = sat_up(pump_ms);
          cool_ms = sat_up(cool_ms);
          mist_ms = sat_up(mist_ms);
          if (pump_on && pump_ms >= pump_run) begin
            pump_on = 1'b0;
            cool_ms = '0;
            ev = EV_STOP;
          end
          if (mist_on && mist_ms >= mist_run) mist_on = 1'b0;
        end
        ACT_SAMPLE: begin
          res_low = it.reservoir_level < res_lvl;
          if (auto_on) begin
            if (pump_on) begin
              if (pump_ms >= MIN_ON_TICKS && it.moisture > off_lvl) begin
                pump_on = 1'b0;
                cool_ms = '0;
                ev = EV_STOP;
              end
            end else if (cool_ms < pump_cool) begin
              // still cooling down
            end else if (it.moisture >= OPEN_LEVEL) begin
              open_s = 1'b1;
            end else if (res_low) begin
              // never run the pump dry
            end else if (it.moisture < on_lvl) begin
              pump_on = 1'b1;
              pump_ms = '0;
              ev = EV_START;
              if (!alert_done) begin
                alert = 1'b1;
                alert_done = 1'b1;
              end
            end else begin
              // wet enough: the next dry spell is a new episode
              alert_done = 1'b0;
            end
            if (!mist_on && $signed(it.temperature) > temp_lvl && it.humidity < hum_lvl) begin
              mist_on = 1'b1;
              mist_ms = '0;
            end
          end
        end
        ACT_PUMP_ON: begin
          if (!pump_on && !res_low) begin
            pump_on = 1'b1;
            pump_ms = '0;
            ev = EV_START;
          end
        end
        ACT_PUMP_OFF: begin
          pump_on = 1'b0;
          cool_ms = '0;
          ev = EV_STOP;
        end
        ACT_MIST_ON: begin
          if (!mist_on) begin
            mist_on = 1'b1;
            mist_ms = '0;
          end
        end
        ACT_MIST_OFF: mist_on = 1'b0;
        ACT_SET_MODE: auto_on = it.mode_value;
        default: ;
      endcase
      r.pump_active      = pump_on;
      r.mist_active      = mist_on;
      r.reservoir_is_low = res_low;
      r.dry_alert        = alert;
      r.sensor_open      = open_s;
      r.pump_event       = ev;
      r.auto_active      = auto_on;
      pending_outputs.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_outputs.size() == 0) begin
        $error("result arrived with no item waiting");
        errors++;
        return;
      end
      want = pending_outputs.pop_front();
      results++;
      check_field("pump_active", want.pump_active, got.pump_active);
      check_field("mist_active", want.mist_active, got.mist_active);
      check_field("reservoir_is_low", want.reservoir_is_low, got.reservoir_is_low);
      check_field("dry_alert", want.dry_alert, got.dry_alert);
      check_field("sensor_open", want.sensor_open, got.sensor_open);
      check_field("pump_event", want.pump_event, got.pump_event);
      check_field("auto_active", want.auto_active, got.auto_active);
      if (want.pump_event == EV_START) starts++;
      if (want.pump_event == EV_STOP) stops++;
      if (want.dry_alert) alerts++;
      if (want.sensor_open) opens++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  pmhc_in_if  in_if();
  pmhc_out_if out_if();
  pmhc_cfg_if cfg_if();

  pump_mist_hysteresis_controller uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  controller_scoreboard sb;
  int burst_left;
  int settings_used;
  int idle_cycles;
  bit long_hold_req;

  // Take results first: a result at this edge always belongs to an earlier item.
  always @(posedge clk_i) begin : monitor
    result_t got;
    item_t   seen;
    bit      moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_if.valid && out_if.ready) begin
        got.pump_active      = out_if.pump_active;
        got.mist_active      = out_if.mist_active;
        got.reservoir_is_low = out_if.reservoir_is_low;
        got.dry_alert        = out_if.dry_alert;
        got.sensor_open      = out_if.sensor_open;
        got.pump_event       = out_if.pump_event;
        got.auto_active      = out_if.auto_active;
        sb.check_result(got);
        moved = 1'b1;
      end
      if (in_if.valid && in_if.ready) begin
        seen.action          = in_if.action;
        seen.moisture        = in_if.moisture;
        seen.reservoir_level = in_if.reservoir_level;
        seen.temperature     = in_if.temperature;
        seen.humidity        = in_if.humidity;
        seen.mode_value      = in_if.mode_value;
        sb.predict_item(seen);
        moved = 1'b1;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        sb.set_reg(cfg_if.index, cfg_if.data);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : receiver
    int hold_left;
    int pattern;
    int pattern_left;
    hold_left = 0;
    pattern = 0;
    pattern_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (pattern_left == 0) begin
        pattern = $urandom_range(0, 3);
        pattern_left = $urandom_range(16, 96);
      end
      pattern_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (pattern)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 3) != 0);
          2: out_if.ready <= ($urandom_range(0, 2) == 0);
          default: out_if.ready <= (pattern_left % 4 != 0);
        endcase
      end
    end
  end

  function automatic item_t mk_item(logic [ACTION_W-1:0] act, int moist, int res, int temp,
                                    int hum, bit mode);
    item_t it;
    it.action          = act;
    it.moisture        = moist[LEVEL_W-1:0];
    it.reservoir_level = res[LEVEL_W-1:0];
    it.temperature     = temp[TEMP_W-1:0];
    it.humidity        = hum[HUM_W-1:0];
    it.mode_value      = mode;
    return it;
  endfunction

  // Bias sample fields toward the current thresholds so every branch gets hit.
  function automatic item_t random_item();
    item_t it;
    int sel, tl, tv;
    tl = int'(sb.temp_lvl);
    case ($urandom_range(0, 9))
      0, 1, 2: it.moisture = (sb.on_lvl == 0) ? '0
                                              : LEVEL_W'($urandom_range(0, sb.on_lvl - 1));
      3, 4:    it.moisture = LEVEL_W'($urandom_range(sb.off_lvl, 4095));
      5:       it.moisture = LEVEL_W'($urandom_range(4088, 4095));
      6, 7:    it.moisture = LEVEL_W'($urandom_range(sb.on_lvl, sb.off_lvl));
      default: it.moisture = LEVEL_W'($urandom_range(0, 4095));
    endcase
    it.reservoir_level = ($urandom_range(0, 4) != 0) ? LEVEL_W'($urandom_range(sb.res_lvl, 4095))
                                                     : LEVEL_W'($urandom_range(0, 4095));
    tv = ($urandom_range(0, 1) != 0) ? int'($urandom_range(tl + 400, 1250)) - 400
                                     : int'($urandom_range(0, 1250)) - 400;
    it.temperature = tv[TEMP_W-1:0];
    it.humidity = ($urandom_range(0, 1) != 0) ? HUM_W'($urandom_range(0, sb.hum_lvl))
                                              : HUM_W'($urandom_range(0, 1000));
    it.mode_value = ($urandom_range(0, 3) != 0);
    sel = $urandom_range(0, 99);
    if (sel < 38)      it.action = ACT_TICK;
    else if (sel < 70) it.action = ACT_SAMPLE;
    else if (sel < 76) it.action = ACT_PUMP_ON;
    else if (sel < 82) it.action = ACT_PUMP_OFF;
    else if (sel < 87) it.action = ACT_MIST_ON;
    else if (sel < 92) it.action = ACT_MIST_OFF;
    else if (sel < 98) it.action = ACT_SET_MODE;
    else               it.action = ACT_UNUSED;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk_i);
    end
    burst_left--;
    @(negedge clk_i);
    in_if.valid           <= 1'b1;
    in_if.action          <= it.action;
    in_if.moisture        <= it.moisture;
    in_if.reservoir_level <= it.reservoir_level;
    in_if.temperature     <= it.temperature;
    in_if.humidity        <= it.humidity;
    in_if.mode_value      <= it.mode_value;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Hold the input off until every expected result has come back.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic apply_settings(input int on_v, input int off_v, input int res_v,
                                input int temp_v, input int hum_v, input int prun_v,
                                input int cool_v, input int mrun_v);
    drain();
    write_reg(REG_ON_LEVEL, on_v);
    write_reg(REG_OFF_LEVEL, off_v);
    write_reg(REG_RES_LEVEL, res_v);
    write_reg(REG_TEMP_LEVEL, temp_v);
    write_reg(REG_HUM_LEVEL, hum_v);
    write_reg(REG_PUMP_RUN, prun_v);
    write_reg(REG_PUMP_COOL, cool_v);
    write_reg(REG_MIST_RUN, mrun_v);
    settings_used++;
  endtask

  initial begin : stimulus
    int on_v, off_v;
    sb = new();
    burst_left = 0;
    settings_used = 1;
    idle_cycles = 0;
    long_hold_req = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = ACT_TICK;
    in_if.moisture = '0;
    in_if.reservoir_level = '0;
    in_if.temperature = '0;
    in_if.humidity = '0;
    in_if.mode_value = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Default levels, cooldown counter starts out expired.
    send_item(mk_item(ACT_SAMPLE, 0, 4095, 850, 0, 1'b0));
    send_item(mk_item(ACT_SAMPLE, 4095, 4095, -400, 1000, 1'b0));
    send_item(mk_item(ACT_TICK, 0, 0, 0, 0, 1'b0));
    send_item(mk_item(ACT_PUMP_ON, 0, 0, 0, 0, 1'b0));
    send_item(mk_item(ACT_MIST_ON, 0, 0, 0, 0, 1'b0));
    send_item(mk_item(ACT_MIST_OFF, 0, 0, 0, 0, 1'b0));
    send_item(mk_item(ACT_PUMP_OFF, 0, 0, 0, 0, 1'b0));
    send_item(mk_item(ACT_PUMP_OFF, 0, 0, 0, 0, 1'b0));
    send_item(mk_item(ACT_SAMPLE, 0, 4095, 0, 0, 1'b0));
    send_item(mk_item(ACT_SET_MODE, 0, 0, 0, 0, 1'b0));
    send_item(mk_item(ACT_SAMPLE, 0, 0, 0, 0, 1'b0));
    send_item(mk_item(ACT_PUMP_ON, 0, 0, 0, 0, 1'b0));
    send_item(mk_item(ACT_SAMPLE, 0, 4095, 850, 0, 1'b0));
    send_item(mk_item(ACT_PUMP_ON, 0, 0, 0, 0, 1'b0));
    send_item(mk_item(ACT_UNUSED, 4095, 4095, -1, 1000, 1'b1));
    send_item(mk_item(ACT_SET_MODE, 0, 0, 0, 0, 1'b1));
    send_item(mk_item(ACT_PUMP_OFF, 0, 0, 0, 0, 1'b0));

    // No cooldown and zero run times: open sensor, dry episodes, instant stop.
    apply_settings(500, 1500, 500, 300, 250, 0, 0, 0);
    send_item(mk_item(ACT_SAMPLE, 4095, 4095, 0, 0, 1'b0));
    send_item(mk_item(ACT_SAMPLE, 4090, 4095, 0, 0, 1'b0));
    send_item(mk_item(ACT_SAMPLE, 4089, 0, 0, 0, 1'b0));
    send_item(mk_item(ACT_SAMPLE, 2000, 4095, 0, 0, 1'b0));
    send_item(mk_item(ACT_SAMPLE, 499, 4095, 0, 0, 1'b0));
    send_item(mk_item(ACT_MIST_ON, 0, 0, 0, 0, 1'b0));
    send_item(mk_item(ACT_TICK, 0, 0, 0, 0, 1'b0));
    send_item(mk_item(ACT_SAMPLE, 0, 4095, 0, 0, 1'b0));
    send_item(mk_item(ACT_PUMP_OFF, 0, 0, 0, 0, 1'b0));

    // Long run and cooldown times: a wet sample cannot stop a freshly started pump.
    apply_settings(500, 1500, 500, 300, 250, 65535, 65535, 65535);
    send_item(mk_item(ACT_PUMP_ON, 0, 0, 0, 0, 1'b0));
    repeat (20) send_item(mk_item(ACT_TICK, 0, 0, 0, 0, 1'b0));
    send_item(mk_item(ACT_SAMPLE, 4000, 4095, -400, 1000, 1'b0));
    send_item(mk_item(ACT_TICK, 0, 0, 0, 0, 1'b0));
    send_item(mk_item(ACT_SAMPLE, 1500, 4095, -400, 1000, 1'b0));
    send_item(mk_item(ACT_SAMPLE, 1501, 4095, -400, 1000, 1'b0));
    send_item(mk_item(ACT_PUMP_ON, 0, 0, 0, 0, 1'b0));
    send_item(mk_item(ACT_MIST_ON, 0, 0, 0, 0, 1'b0));
    for (int k = 0; k < 40; k++) begin
      send_item(mk_item(ACT_TICK, 0, 0, 0, 0, 1'b0));
      if (k % 10 == 0)
        send_item(mk_item(ACT_SAMPLE, $urandom_range(0, 1500), 4095, -400, 1000, 1'b0));
    end
    send_item(mk_item(ACT_SAMPLE, 0, 4095, 850, 0, 1'b0));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: apply_settings(0, 0, 0, -400, 0, 1, 0, 1);
        1: apply_settings(4095, 4095, 4095, 850, 1000, 65535, 65535, 65535);
        default: begin
          on_v = $urandom_range(0, 2000);
          off_v = $urandom_range(on_v, 4095);
          apply_settings(on_v, off_v, $urandom_range(0, 1200),
                         int'($urandom_range(0, 1250)) - 400, $urandom_range(0, 1000),
                         $urandom_range(1, 50), $urandom_range(0, 60), $urandom_range(1, 40));
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 30) long_hold_req = 1'b1;
        if (p == 3 && n == 50) drain();
        send_item(random_item());
      end
    end

    drain();
    $display("Checked %0d results from %0d items over %0d register settings",
             sb.results, sb.items, settings_used);
    $display("Saw %0d pump starts, %0d pump stops, %0d dry alerts, %0d open-sensor samples",
             sb.starts, sb.stops, sb.alerts, sb.opens);
    if (sb.errors == 0 && sb.pending_outputs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
